// ===== rtl/core/ecx_pkg.sv =====
// ----------------------------------------------------------------------------
// ecx_pkg
// Shared types and constants of the encoder count extender.
// ----------------------------------------------------------------------------
package ecx_pkg;

    typedef logic signed [15:0] raw_count_t;
    typedef logic signed [31:0] total_count_t;
    typedef logic signed [31:0] gain_t;
    typedef logic signed [63:0] position_t;

    // Depth of the queue between the count tracker and the scaling stage.
    // It must be a power of two so that the pointers wrap by themselves.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // One tracked cycle, waiting for scaling.
    typedef struct packed {
        total_count_t total_count;
        raw_count_t   shown_raw_count;
        raw_count_t   captured_latch;
        logic         preset_pending;
        logic         rising_armed;
        logic         falling_armed;
    } track_t;

endpackage

// ===== rtl/core/ecx_sample_if.sv =====
// ----------------------------------------------------------------------------
// ecx_sample_if
// Channel that carries one process-data cycle into the block.
// ----------------------------------------------------------------------------
interface ecx_sample_if;

    logic                valid;
    logic                ready;
    logic                link_operational;
    ecx_pkg::raw_count_t module_count;
    ecx_pkg::raw_count_t module_latch;
    logic                latch_event;
    logic                preset_done;
    logic                clear_request;
    logic                preset_request;
    logic                arm_rising;
    logic                arm_falling;

    modport source
    (
        output valid,
        input  ready,
        output link_operational,
        output module_count,
        output module_latch,
        output latch_event,
        output preset_done,
        output clear_request,
        output preset_request,
        output arm_rising,
        output arm_falling
    );

    modport sink
    (
        input  valid,
        output ready,
        input  link_operational,
        input  module_count,
        input  module_latch,
        input  latch_event,
        input  preset_done,
        input  clear_request,
        input  preset_request,
        input  arm_rising,
        input  arm_falling
    );

endinterface

// ===== rtl/core/ecx_result_if.sv =====
// ----------------------------------------------------------------------------
// ecx_result_if
// Channel that carries one extended count and position out of the block.
// ----------------------------------------------------------------------------
interface ecx_result_if;

    logic                  valid;
    logic                  ready;
    ecx_pkg::total_count_t total_count;
    ecx_pkg::position_t    position;
    ecx_pkg::raw_count_t   shown_raw_count;
    ecx_pkg::raw_count_t   captured_latch;
    logic                  preset_pending;
    logic                  rising_armed;
    logic                  falling_armed;

    modport source
    (
        output valid,
        input  ready,
        output total_count,
        output position,
        output shown_raw_count,
        output captured_latch,
        output preset_pending,
        output rising_armed,
        output falling_armed
    );

    modport sink
    (
        input  valid,
        output ready,
        input  total_count,
        input  position,
        input  shown_raw_count,
        input  captured_latch,
        input  preset_pending,
        input  rising_armed,
        input  falling_armed
    );

endinterface

// ===== rtl/core/ecx_front.sv =====
// ----------------------------------------------------------------------------
// ecx_front
// Count tracker: takes process-data words, keeps the raw-count history and
// the host request flags, and pushes one tracked word per operational cycle.
// ----------------------------------------------------------------------------
module ecx_front
(
    input  logic                clk,
    input  logic                rst_n,
    ecx_sample_if.sink          sample,
    input  logic                queue_full,
    output logic                push,
    output ecx_pkg::track_t     push_data
);

    ecx_pkg::raw_count_t   previous_raw_reg, previous_raw_next;
    ecx_pkg::total_count_t accumulated_reg, accumulated_next;
    logic                  first_cycle_reg, first_cycle_next;
    logic                  was_operational_reg, was_operational_next;
    ecx_pkg::raw_count_t   held_raw_reg, held_raw_next;
    ecx_pkg::raw_count_t   latch_copy_reg, latch_copy_next;
    logic                  preset_flag_reg, preset_flag_next;
    logic                  rising_enable_reg, rising_enable_next;
    logic                  falling_enable_reg, falling_enable_next;

    logic accept;

    // A word is taken whenever the queue has room, operational or not.
    assign sample.ready = !queue_full;
    assign accept       = sample.valid && !queue_full;
    assign push         = accept && sample.link_operational;

    always_comb
    begin
        ecx_pkg::raw_count_t   prev;
        ecx_pkg::raw_count_t   delta;
        ecx_pkg::total_count_t acc;
        logic                  pf;
        logic                  re;
        logic                  fe;
        logic                  first;

        pf    = preset_flag_reg || sample.preset_request;
        re    = rising_enable_reg || sample.arm_rising;
        fe    = falling_enable_reg || sample.arm_falling;
        prev  = was_operational_reg ? previous_raw_reg : sample.module_count;
        acc   = accumulated_reg;
        first = first_cycle_reg;

        if (sample.preset_done)
        begin
            prev = sample.module_count;
            pf   = 1'b0;
        end

        held_raw_next = pf ? held_raw_reg : sample.module_count;

        if (first || sample.clear_request)
        begin
            first = 1'b0;
            prev  = sample.module_count;
            acc   = '0;
        end

        latch_copy_next = latch_copy_reg;
        if (sample.latch_event)
        begin
            latch_copy_next = sample.module_latch;
            prev            = sample.module_latch;
            acc             = '0;
            re              = 1'b0;
            fe              = 1'b0;
        end

        delta = sample.module_count - prev;
        acc   = acc + ecx_pkg::total_count_t'(delta);

        accumulated_next     = acc;
        previous_raw_next    = sample.module_count;
        first_cycle_next     = first;
        was_operational_next = 1'b1;
        preset_flag_next     = pf;
        rising_enable_next   = re;
        falling_enable_next  = fe;

        push_data.total_count     = acc;
        push_data.shown_raw_count = held_raw_next;
        push_data.captured_latch  = latch_copy_next;
        push_data.preset_pending  = pf;
        push_data.rising_armed    = re;
        push_data.falling_armed   = fe;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            previous_raw_reg    <= '0;
            accumulated_reg     <= '0;
            first_cycle_reg     <= 1'b1;
            was_operational_reg <= 1'b0;
            held_raw_reg        <= '0;
            latch_copy_reg      <= '0;
            preset_flag_reg     <= 1'b0;
            rising_enable_reg   <= 1'b0;
            falling_enable_reg  <= 1'b0;
        end
        else if (accept)
        begin
            if (sample.link_operational)
            begin
                previous_raw_reg    <= previous_raw_next;
                accumulated_reg     <= accumulated_next;
                first_cycle_reg     <= first_cycle_next;
                was_operational_reg <= was_operational_next;
                held_raw_reg        <= held_raw_next;
                latch_copy_reg      <= latch_copy_next;
                preset_flag_reg     <= preset_flag_next;
                rising_enable_reg   <= rising_enable_next;
                falling_enable_reg  <= falling_enable_next;
            end
            else
            begin
                // Dropping out of operational state only forces a resync later.
                was_operational_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/core/ecx_queue.sv =====
// ----------------------------------------------------------------------------
// ecx_queue
// Small register queue between the count tracker and the scaling stage.
// ----------------------------------------------------------------------------
module ecx_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ecx_pkg::track_t push_data,
    output logic            full,
    input  logic            pop,
    output ecx_pkg::track_t pop_data,
    output logic            empty
);

    ecx_pkg::track_t                   entry_reg [ecx_pkg::QUEUE_DEPTH];
    logic [ecx_pkg::QUEUE_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [ecx_pkg::QUEUE_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [ecx_pkg::QUEUE_CNT_W-1:0]   fill_reg, fill_next;

    assign full     = (fill_reg == ecx_pkg::QUEUE_CNT_W'(ecx_pkg::QUEUE_DEPTH));
    assign empty    = (fill_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/core/ecx_back.sv =====
// ----------------------------------------------------------------------------
// ecx_back
// Scaling stage: multiplies the extended count by the gain and holds the
// finished word in the output register until it is taken.
// ----------------------------------------------------------------------------
module ecx_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  ecx_pkg::gain_t  gain,
    input  logic            queue_empty,
    input  ecx_pkg::track_t queue_data,
    output logic            pop,
    ecx_result_if.source    result
);

    logic               valid_reg;
    ecx_pkg::track_t    track_reg;
    ecx_pkg::position_t position_reg;
    ecx_pkg::position_t position_next;

    // Both operands are signed 32-bit values; the casts only sign-extend so
    // that the full 64-bit product is kept.
    assign position_next = ecx_pkg::position_t'(queue_data.total_count)
                         * ecx_pkg::position_t'(gain);

    assign pop = !queue_empty && (!valid_reg || result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            track_reg    <= queue_data;
            position_reg <= position_next;
        end
    end

    assign result.valid           = valid_reg;
    assign result.total_count     = track_reg.total_count;
    assign result.position        = position_reg;
    assign result.shown_raw_count = track_reg.shown_raw_count;
    assign result.captured_latch  = track_reg.captured_latch;
    assign result.preset_pending  = track_reg.preset_pending;
    assign result.rising_armed    = track_reg.rising_armed;
    assign result.falling_armed   = track_reg.falling_armed;

endmodule

// ===== rtl/core/encoder_count_extender_with_latch.sv =====
// ----------------------------------------------------------------------------
// encoder_count_extender_with_latch
// Extends a wrapping 16-bit encoder count to 32 bits and scales it to a
// fixed-point position, with external latch and preset handling.
// ----------------------------------------------------------------------------
// Each word on the sample channel is one process-data cycle of an encoder
// channel. A word with link_operational low is taken, gives no result and only
// marks the link as dropped, so the next operational word resynchronizes the
// raw count. Every operational word gives exactly one result word. The block
// takes one word per clock cycle when the result side keeps up. A taken word
// is written into the tracker queue and then moves into the multiplier output
// register, where it is presented on the result channel until it is taken.
// The sustained rate of one word a cycle when the result side keeps up is set
// by the count tracker, whose state update is combinational, and by the one
// 32 x 32 signed multiplier in the scaling stage. The position gain register
// is written through cfg_wr_en and cfg_wr_data and must only be changed while
// no words are in flight.
// ----------------------------------------------------------------------------
module encoder_count_extender_with_latch
#(
    parameter int GAIN_FRACTION_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    ecx_sample_if.sink           sample,
    ecx_result_if.source         result,
    input  logic                 cfg_wr_en,
    input  ecx_pkg::gain_t       cfg_wr_data
);

    // The gain resets to 1.0 in the chosen fixed-point format.
    localparam logic [31:0] GAIN_RESET = 32'd1 << GAIN_FRACTION_BITS;

    ecx_pkg::gain_t  gain_reg;

    // Connections between the tracker, the queue and the scaling stage.
    logic            queue_full;
    logic            queue_empty;
    logic            push;
    logic            pop;
    ecx_pkg::track_t push_data;
    ecx_pkg::track_t pop_data;

    // The gain register; its value feeds the multiplier directly.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= ecx_pkg::gain_t'(GAIN_RESET);
        end
        else if (cfg_wr_en)
        begin
            gain_reg <= cfg_wr_data;
        end
    end

    // The tracker keeps all per-channel state and decides, word by word,
    // whether a result is due. It stalls only when the queue is full.
    ecx_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample     (sample),
        .queue_full (queue_full),
        .push       (push),
        .push_data  (push_data)
    );

    // The queue lets the tracker keep taking words while a finished result
    // waits on the output side.
    ecx_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (queue_empty)
    );

    // The scaling stage multiplies into its output register and presents
    // the word until the result channel takes it.
    ecx_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .gain        (gain_reg),
        .queue_empty (queue_empty),
        .queue_data  (pop_data),
        .pop         (pop),
        .result      (result)
    );

endmodule

// ===== tb/sv/ecx_position_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ecx_position_checker
// Watches both channels of the count extender, predicts every result word
// from the sample words and the gain writes, and compares in order.
// ----------------------------------------------------------------------------
module ecx_position_checker
#(
    parameter int GAIN_FRACTION_BITS = 16
)
(
    input  logic            clk,
    input  logic            rst_n,
    ecx_sample_if           sample,
    ecx_result_if           result,
    input  logic            cfg_wr_en,
    input  ecx_pkg::gain_t  cfg_wr_data,
    output int              mismatch_count,
    output int              results_in_flight
);

    typedef struct {
        ecx_pkg::total_count_t total_count;
        ecx_pkg::position_t    position;
        ecx_pkg::raw_count_t   shown_raw_count;
        ecx_pkg::raw_count_t   captured_latch;
        logic                  preset_pending;
        logic                  rising_armed;
        logic                  falling_armed;
    } position_word_t;

    // Tracker state, kept in step with the block.
    ecx_pkg::gain_t        gain;
    ecx_pkg::raw_count_t   last_raw;
    ecx_pkg::total_count_t running_total;
    logic                  first_word;
    logic                  link_was_up;
    ecx_pkg::raw_count_t   display_raw;
    ecx_pkg::raw_count_t   latch_value;
    logic                  preset_held;
    logic                  rise_enable;
    logic                  fall_enable;

    position_word_t expected_positions[$];
    int             errors;

    task automatic reset_tracker();
        gain          = ecx_pkg::gain_t'(1) <<< GAIN_FRACTION_BITS;
        last_raw      = '0;
        running_total = '0;
        first_word    = 1'b1;
        link_was_up   = 1'b0;
        display_raw   = '0;
        latch_value   = '0;
        preset_held   = 1'b0;
        rise_enable   = 1'b0;
        fall_enable   = 1'b0;
    endtask

    // Advances the tracker by one sample word and queues the position word
    // that an operational word produces.
    task automatic track_sample();
        ecx_pkg::raw_count_t count;
        ecx_pkg::raw_count_t delta;
        logic signed [63:0]  wide_total;
        logic signed [63:0]  wide_gain;
        position_word_t      word;
        count = sample.module_count;
        if (!sample.link_operational)
        begin
            link_was_up = 1'b0;
            return;
        end
        preset_held = preset_held | sample.preset_request;
        rise_enable = rise_enable | sample.arm_rising;
        fall_enable = fall_enable | sample.arm_falling;
        if (!link_was_up)
            last_raw = count;
        if (sample.preset_done)
        begin
            last_raw    = count;
            preset_held = 1'b0;
        end
        if (!preset_held)
            display_raw = count;
        if (first_word || sample.clear_request)
        begin
            first_word    = 1'b0;
            last_raw      = count;
            running_total = '0;
        end
        if (sample.latch_event)
        begin
            latch_value   = sample.module_latch;
            last_raw      = sample.module_latch;
            running_total = '0;
            rise_enable   = 1'b0;
            fall_enable   = 1'b0;
        end
        delta         = count - last_raw;
        running_total = running_total + delta;
        last_raw      = count;
        link_was_up   = 1'b1;
        wide_total    = running_total;
        wide_gain     = gain;
        word.total_count     = running_total;
        word.position        = wide_total * wide_gain;
        word.shown_raw_count = display_raw;
        word.captured_latch  = latch_value;
        word.preset_pending  = preset_held;
        word.rising_armed    = rise_enable;
        word.falling_armed   = fall_enable;
        expected_positions.push_back(word);
    endtask

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic check_result();
        position_word_t want;
        if (expected_positions.size() == 0)
        begin
            $display("%0t: result word arrived with nothing expected, total_count %h",
                     $time, result.total_count);
            errors++;
            return;
        end
        want = expected_positions.pop_front();
        check_field("total_count", 64'(want.total_count), 64'(result.total_count));
        check_field("position", want.position, result.position);
        check_field("shown_raw_count", 64'(want.shown_raw_count), 64'(result.shown_raw_count));
        check_field("captured_latch", 64'(want.captured_latch), 64'(result.captured_latch));
        check_field("preset_pending", 64'(want.preset_pending), 64'(result.preset_pending));
        check_field("rising_armed", 64'(want.rising_armed), 64'(result.rising_armed));
        check_field("falling_armed", 64'(want.falling_armed), 64'(result.falling_armed));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_tracker();
            expected_positions.delete();
            errors = 0;
        end
        else
        begin
            if (result.valid && result.ready)
                check_result();
            if (sample.valid && sample.ready)
                track_sample();
            if (cfg_wr_en)
                gain = cfg_wr_data;
        end
        mismatch_count    <= errors;
        results_in_flight <= expected_positions.size();
    end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the encoder count extender.
// ----------------------------------------------------------------------------
// The run walks through several gain settings, the extremes among them. The
// first setting opens with a directed list of corner words; every setting
// then gets random words shaped like a real encoder: a count that drifts by
// small steps, occasional jumps, latch events, and preset requests that the
// module answers a few words later. One setting also gets a run of the
// largest positive delta at full rate. The checker beside the block does
// all prediction and comparison; this module only drives and decides.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int FRACTION_BITS  = 16;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int RANDOM_WORDS   = 185;
    localparam int SWEEP_WORDS    = 40;
    localparam int LONG_HOLD      = 100;
    localparam int HOLD_AFTER     = 300;

    typedef struct packed {
        logic                link_operational;
        ecx_pkg::raw_count_t module_count;
        ecx_pkg::raw_count_t module_latch;
        logic                latch_event;
        logic                preset_done;
        logic                clear_request;
        logic                preset_request;
        logic                arm_rising;
        logic                arm_falling;
    } sample_word_t;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           cfg_wr_en;
    ecx_pkg::gain_t cfg_wr_data;
    int             mismatch_count;
    int             results_in_flight;
    int             cycle_count = 0;

    // Shared pacing state. While full_rate is set, neither side idles.
    logic  full_rate = 1'b0;
    int    words_sent = 0;
    int    results_taken = 0;

    // The simulated encoder: its count and the number of words until the
    // module reports that an outstanding preset has completed.
    ecx_pkg::raw_count_t encoder_count = '0;
    int                  preset_countdown = 0;

    ecx_sample_if sample_ch();
    ecx_result_if result_ch();

    encoder_count_extender_with_latch
    #(
        .GAIN_FRACTION_BITS (FRACTION_BITS)
    )
    uut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample      (sample_ch),
        .result      (result_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    ecx_position_checker
    #(
        .GAIN_FRACTION_BITS (FRACTION_BITS)
    )
    checker_inst
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .sample            (sample_ch),
        .result            (result_ch),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .mismatch_count    (mismatch_count),
        .results_in_flight (results_in_flight)
    );

    always #4 clk = ~clk;

    // A run that hangs never reaches the verdict, so the cycle counter ends it.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic sample_word_t make_word(logic op, ecx_pkg::raw_count_t count,
                                               ecx_pkg::raw_count_t latch,
                                               logic latch_ev, logic done, logic clear,
                                               logic preset, logic rise, logic fall);
        sample_word_t w;
        w.link_operational = op;
        w.module_count     = count;
        w.module_latch     = latch;
        w.latch_event      = latch_ev;
        w.preset_done      = done;
        w.clear_request    = clear;
        w.preset_request   = preset;
        w.arm_rising       = rise;
        w.arm_falling      = fall;
        return w;
    endfunction

    // Offers one sample word and returns at the edge where it is taken. The
    // valid line is left high, so back-to-back words need no extra edge.
    task automatic send_word(input sample_word_t w);
        int gap;
        gap = (full_rate || ((words_sent / 50) % 5 == 3)) ? 0 : $urandom_range(0, 7);
        if (gap != 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.link_operational <= w.link_operational;
        sample_ch.module_count     <= w.module_count;
        sample_ch.module_latch     <= w.module_latch;
        sample_ch.latch_event      <= w.latch_event;
        sample_ch.preset_done      <= w.preset_done;
        sample_ch.clear_request    <= w.clear_request;
        sample_ch.preset_request   <= w.preset_request;
        sample_ch.arm_rising       <= w.arm_rising;
        sample_ch.arm_falling      <= w.arm_falling;
        sample_ch.valid            <= 1'b1;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        words_sent++;
    endtask

    // Builds one word of ordinary encoder traffic. Most words move the count
    // by a small step; a few jump by the widest deltas or to noise. A preset
    // request is held by the host until the module reports it done.
    task automatic next_random_word(output sample_word_t w);
        int                  step;
        int                  drift;
        ecx_pkg::raw_count_t latch;
        logic                preset;
        logic                done;
        step = $urandom_range(0, 31);
        if (step == 0)
            encoder_count = ecx_pkg::raw_count_t'($urandom);
        else if (step == 1)
            encoder_count = encoder_count + 16'sh7FFF;
        else if (step == 2)
            encoder_count = encoder_count + 16'sh8000;
        else
        begin
            drift = $urandom_range(0, 600) - 300;
            encoder_count = encoder_count + drift[15:0];
        end
        if ($urandom_range(0, 3) == 0)
            latch = ecx_pkg::raw_count_t'($urandom);
        else
            latch = encoder_count - ecx_pkg::raw_count_t'($urandom_range(0, 200));
        if (preset_countdown == 0)
        begin
            preset = ($urandom_range(0, 24) == 0);
            done   = ($urandom_range(0, 49) == 0);
            if (preset)
                preset_countdown = $urandom_range(1, 8);
        end
        else
        begin
            preset_countdown--;
            preset = 1'b1;
            done   = (preset_countdown == 0);
        end
        w = make_word($urandom_range(0, 11) != 0, encoder_count, latch,
                      $urandom_range(0, 19) == 0, done, $urandom_range(0, 39) == 0,
                      preset, $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0);
    endtask

    // Stops offering words and waits until every result word is back. Words
    // with the link down give no result, so a few more edges let the block
    // finish with anything still inside it.
    task automatic drain_block();
        sample_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (results_in_flight != 0);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_gain(input ecx_pkg::gain_t value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Corner words, sent once after reset with the reset gain of one.
    task automatic send_corner_words();
        // The first word only resynchronizes, then the count wraps upward by
        // one, takes the most negative delta, and then the most positive one.
        send_word(make_word(1'b1, 16'sh7FFF, 16'sh0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_word(make_word(1'b1, 16'sh8000, 16'sh0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_word(make_word(1'b1, 16'sh0000, 16'sh0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_word(make_word(1'b1, 16'sh7FFF, 16'sh0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        // Arm both edges, then a latch at the most negative value disarms them.
        send_word(make_word(1'b1, 16'shFFFF, 16'sh0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1));
        send_word(make_word(1'b1, 16'sh0010, 16'sh8000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        // An arm raised together with a latch is dropped at once.
        send_word(make_word(1'b1, 16'sh0000, 16'sh7FFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
        // A preset request freezes the shown count until it is done.
        send_word(make_word(1'b1, 16'sh1234, 16'sh0000, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
        send_word(make_word(1'b1, 16'sh1300, 16'sh0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        // The link drops, then the next operational word resynchronizes.
        send_word(make_word(1'b0, 16'sh5555, 16'sh2222, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
        send_word(make_word(1'b1, 16'sh6000, 16'sh0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_word(make_word(1'b1, 16'sh6100, 16'sh0000, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        // A request and its completion in the same word cancel out.
        send_word(make_word(1'b1, 16'sh6200, 16'sh0000, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0));
        send_word(make_word(1'b1, 16'sh6300, 16'sh0000, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
        send_word(make_word(1'b1, 16'shFFFF, 16'shFFFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
        send_word(make_word(1'b1, 16'sh0000, 16'sh0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_word(make_word(1'b0, 16'sh8000, 16'sh8000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_word(make_word(1'b0, 16'sh7FFF, 16'sh7FFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_word(make_word(1'b1, 16'sh8000, 16'sh0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
        send_word(make_word(1'b1, 16'sh8001, 16'sh0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
    endtask

    // Clears the total and then steps the count by the largest positive delta
    // at full rate, so that the total climbs as fast as the block allows.
    task automatic sweep_max_delta();
        full_rate = 1'b1;
        send_word(make_word(1'b1, encoder_count, 16'sh0000,
                            1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
        repeat (SWEEP_WORDS)
        begin
            encoder_count = encoder_count + 16'sh7FFF;
            send_word(make_word(1'b1, encoder_count, 16'sh0000,
                                1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        end
        full_rate = 1'b0;
    endtask

    // Result side: a random stall before each word, stretches without stalls,
    // and one long hold while the sender keeps offering, so that the block
    // fills up and stops taking samples.
    initial
    begin
        int  gap;
        logic long_hold_done;
        long_hold_done = 1'b0;
        result_ch.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (!long_hold_done && results_taken == HOLD_AFTER)
            begin
                gap = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            else if (full_rate || ((results_taken / 40) % 5 == 1))
                gap = 0;
            else
                gap = $urandom_range(0, 7);
            if (gap != 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge clk);
            while (!result_ch.valid)
                @(posedge clk);
            results_taken++;
        end
    end

    initial
    begin
        ecx_pkg::gain_t phase_gain[7];
        sample_word_t   w;
        phase_gain[0] = 32'sh7FFF_FFFF;
        phase_gain[1] = 32'sh8000_0000;
        phase_gain[2] = 32'sh0000_0000;
        phase_gain[3] = 32'shFFFF_FFFF;
        phase_gain[4] = ecx_pkg::gain_t'($urandom);
        phase_gain[5] = 32'sh0000_0001;
        phase_gain[6] = 32'sh0001_0000;

        sample_ch.valid            <= 1'b0;
        sample_ch.link_operational <= 1'b0;
        sample_ch.module_count     <= '0;
        sample_ch.module_latch     <= '0;
        sample_ch.latch_event      <= 1'b0;
        sample_ch.preset_done      <= 1'b0;
        sample_ch.clear_request    <= 1'b0;
        sample_ch.preset_request   <= 1'b0;
        sample_ch.arm_rising       <= 1'b0;
        sample_ch.arm_falling      <= 1'b0;
        cfg_wr_en                  <= 1'b0;
        cfg_wr_data                <= '0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // First setting: the reset gain, corner words, then random traffic.
        send_corner_words();
        repeat (RANDOM_WORDS)
        begin
            next_random_word(w);
            send_word(w);
        end

        // The remaining settings; the most negative gain also gets the
        // full-rate run of the largest positive delta.
        for (int p = 0; p < 7; p++)
        begin
            drain_block();
            write_gain(phase_gain[p]);
            if (phase_gain[p] == 32'sh8000_0000)
                sweep_max_delta();
            repeat (RANDOM_WORDS)
            begin
                next_random_word(w);
                send_word(w);
            end
        end

        drain_block();
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/ecx_pkg.sv
rtl/core/ecx_sample_if.sv
rtl/core/ecx_result_if.sv
rtl/core/ecx_front.sv
rtl/core/ecx_queue.sv
rtl/core/ecx_back.sv
rtl/core/encoder_count_extender_with_latch.sv
tb/sv/ecx_position_checker.sv
tb/sv/tb_top.sv
